// ===== hw/rtl/ltcp_pkg.sv =====
// Package for the LRU tag cache policy block.
// Holds the request codes, the cell operations, the state type and the cell control struct.
// Used by ltcp_cell, lru_tag_cache_policy, ltcp_checker and the testbench.
`default_nettype none

package ltcp_pkg;

   // Fixed field widths of the item, result and capacity channels.
   localparam int TAG_W      = 31;
   localparam int CAP_W      = 5;
   localparam int RSP_SLOT_W = 4;
   localparam int OCC_W      = 5;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Most evictions that one trim item performs.
   localparam int MAX_TRIM   = 16;
   localparam int TRIM_CNT_W = $clog2(MAX_TRIM);

   // Request codes carried on req_type.
   typedef enum logic [1:0] {
      REQ_ACCESS = 2'd0,
      REQ_CLEAR  = 2'd1,
      REQ_TRIM   = 2'd2,
      REQ_NOP    = 2'd3
   } ltcp_req_type;

   // Operation applied to the row of cells in one cycle.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_HIT,
      OP_EVICT,
      OP_EVICT_INSERT,
      OP_INSERT
   } ltcp_op_type;

   // Control sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ltcp_state_type;

   // Control broadcast to every cell.
   typedef struct packed {
      logic              cmp_en;
      logic [TAG_W-1:0]  cmp_tag;
      ltcp_op_type       op;
      logic [TAG_W-1:0]  new_tag;
   } ltcp_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lru_tag_cache_policy.sv =====
// The result is registered: an item is compared against all tags in the cycle it is
// accepted, and the row of cells shifts and the result register loads in the next one.
// No new item is taken while busy; busy holds while an item is being executed.
// A trim gives one result per eviction, with rsp_last on the final one; busy holds meanwhile.
// Results cannot be stalled by the receiver. Synchronous reset empties the store,
// clears the slot map and sets capacity to 16; there is no clearing pass.
`default_nettype none

module lru_tag_cache_policy
   import ltcp_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Item channel
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_type,
   input  wire logic [TAG_W-1:0]  req_item_index,
   input  wire logic              req_fill_ok,
   // Result channel
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic                   rsp_inserted,
   output logic                   rsp_evicted_valid,
   output logic [TAG_W-1:0]       rsp_evicted_index,
   output logic [RSP_SLOT_W-1:0]  rsp_slot,
   output logic [OCC_W-1:0]       rsp_occupancy,
   output logic                   rsp_last,
   // Capacity register write channel
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CAP_W-1:0]  csr_wdata
);

   localparam int CW   = $clog2(ENTRIES + 1);
   localparam int SW   = $clog2(ENTRIES);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

   ltcp_state_type            state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [ENTRIES-1:0]        used_ff, used_in;
   logic [CAP_W-1:0]          cap_ff;
   ltcp_req_type              type_ff;
   logic [TAG_W-1:0]          tag_ff;
   logic                      fill_ff;
   logic [TRIM_CNT_W-1:0]     trim_n_ff, trim_n_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic                      rsp_ins_ff, rsp_ins_in;
   logic                      rsp_ev_ff, rsp_ev_in;
   logic [TAG_W-1:0]          rsp_evidx_ff, rsp_evidx_in;
   logic [SW-1:0]             rsp_slot_ff, rsp_slot_in;
   logic [OCC_W-1:0]          rsp_occ_ff, rsp_occ_in;
   logic                      rsp_last_ff, rsp_last_in;

   ltcp_ctl_type              ctl;
   logic [SW-1:0]             new_slot;
   logic [CW-1:0]             eff_cap;
   logic [SW-1:0]             free_slot;
   logic                      accept;

   logic [TAG_W-1:0]          cell_tag [ENTRIES];
   logic [SW-1:0]             cell_slot [ENTRIES];
   logic                      seen_chain [ENTRIES+1];
   logic [SW-1:0]             slot_chain [ENTRIES+1];

   assign busy      = (state_ff == ST_EXEC);
   assign csr_ready = !busy;
   assign accept    = start && !busy;

   // Capacity clamped to the range one to ENTRIES.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CW'(1);
      end else if (CMPW'(cap_ff) > CMPW'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end else begin
         eff_cap = CW'(cap_ff);
      end
   end

   // Lowest free data slot.
   always_comb begin
      free_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_slot = SW'(i);
         end
      end
   end

   // Row of cells, oldest entry at position zero.
   assign seen_chain[0] = 1'b0;
   assign slot_chain[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      logic [TAG_W-1:0] up_tag;
      logic [SW-1:0]    up_slot;
      if (g == ENTRIES - 1) begin : g_top
         assign up_tag  = '0;
         assign up_slot = '0;
      end else begin : g_mid
         assign up_tag  = cell_tag[g+1];
         assign up_slot = cell_slot[g+1];
      end
      ltcp_cell #(
         .POS (g),
         .CW  (CW),
         .SW  (SW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .new_slot    (new_slot),
         .up_tag      (up_tag),
         .up_slot     (up_slot),
         .seen_in     (seen_chain[g]),
         .slot_or_in  (slot_chain[g]),
         .tag         (cell_tag[g]),
         .slot        (cell_slot[g]),
         .seen_out    (seen_chain[g+1]),
         .slot_or_out (slot_chain[g+1])
      );
   end

   // Sequencer: next state, cell operation and result fields.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      trim_n_in    = trim_n_ff;
      ctl.cmp_en   = 1'b0;
      ctl.cmp_tag  = req_item_index;
      ctl.op       = OP_NONE;
      ctl.new_tag  = tag_ff;
      new_slot     = '0;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = 1'b0;
      rsp_ins_in   = 1'b0;
      rsp_ev_in    = 1'b0;
      rsp_evidx_in = '0;
      rsp_slot_in  = '0;
      rsp_last_in  = 1'b1;
      rsp_occ_in   = OCC_W'(count_ff);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.cmp_en = 1'b1;
               trim_n_in  = '0;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            case (type_ff)
               REQ_ACCESS: begin
                  if (seen_chain[ENTRIES]) begin
                     // Hit: move the entry to the most recent position.
                     ctl.op      = OP_HIT;
                     new_slot    = slot_chain[ENTRIES];
                     rsp_hit_in  = 1'b1;
                     rsp_slot_in = slot_chain[ENTRIES];
                  end else if (fill_ff && (count_ff >= eff_cap)) begin
                     // Full miss: the oldest entry gives up its slot to the new tag.
                     ctl.op       = OP_EVICT_INSERT;
                     new_slot     = cell_slot[0];
                     rsp_ins_in   = 1'b1;
                     rsp_ev_in    = 1'b1;
                     rsp_evidx_in = cell_tag[0];
                     rsp_slot_in  = cell_slot[0];
                  end else if (fill_ff) begin
                     // Miss with room: take the lowest free slot.
                     ctl.op             = OP_INSERT;
                     new_slot           = free_slot;
                     used_in[free_slot] = 1'b1;
                     count_in           = count_ff + CW'(1);
                     rsp_ins_in         = 1'b1;
                     rsp_slot_in        = free_slot;
                  end
               end
               REQ_CLEAR: begin
                  count_in = '0;
                  used_in  = '0;
               end
               REQ_TRIM: begin
                  if (count_ff > eff_cap) begin
                     // Evict the oldest entry; continue while above capacity, up to MAX_TRIM evictions.
                     ctl.op                = OP_EVICT;
                     used_in[cell_slot[0]] = 1'b0;
                     count_in              = count_ff - CW'(1);
                     trim_n_in             = trim_n_ff + TRIM_CNT_W'(1);
                     rsp_ev_in             = 1'b1;
                     rsp_evidx_in          = cell_tag[0];
                     rsp_slot_in           = cell_slot[0];
                     rsp_last_in           = (count_in <= eff_cap) ||
                                             (trim_n_ff == TRIM_CNT_W'(MAX_TRIM - 1));
                     if (!rsp_last_in) begin
                        state_in = ST_EXEC;
                     end
                  end
               end
               default: begin
               end
            endcase
            rsp_occ_in = OCC_W'(count_in);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         cap_ff       <= CAP_RESET;
         trim_n_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         trim_n_ff    <= trim_n_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // Item and result payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= ltcp_req_type'(req_type);
         tag_ff  <= req_item_index;
         fill_ff <= req_fill_ok;
      end
      rsp_hit_ff   <= rsp_hit_in;
      rsp_ins_ff   <= rsp_ins_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_evidx_ff <= rsp_evidx_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_inserted      = rsp_ins_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_index = rsp_evidx_ff;
   assign rsp_slot          = RSP_SLOT_W'(rsp_slot_ff);
   assign rsp_occupancy     = rsp_occ_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ltcp_cell.sv =====
// One position of the recency row: holds a tag and its data slot.
// Compares its tag, takes its upper neighbour's entry on a shift or loads the new entry, and passes match chains on.
// Depends on ltcp_pkg.
`default_nettype none

module ltcp_cell
   import ltcp_pkg::*;
#(
   parameter int POS = 0,
   parameter int CW  = 5,
   parameter int SW  = 4
) (
   input  wire logic              clock,
   input  wire ltcp_ctl_type      ctl,
   input  wire logic [CW-1:0]     count,
   input  wire logic [SW-1:0]     new_slot,
   input  wire logic [TAG_W-1:0]  up_tag,
   input  wire logic [SW-1:0]     up_slot,
   input  wire logic              seen_in,
   input  wire logic [SW-1:0]     slot_or_in,
   output logic [TAG_W-1:0]       tag,
   output logic [SW-1:0]          slot,
   output logic                   seen_out,
   output logic [SW-1:0]          slot_or_out
);

   localparam logic [CW-1:0] MY_POS   = CW'(POS);
   localparam logic [CW-1:0] NEXT_POS = CW'(POS + 1);

   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic             match_ff, match_in;
   logic             occupied;
   logic             shift_en;
   logic             load_en;

   assign occupied = (MY_POS < count);

   // Match chains: a hit at or below this position, and the slot of the hit entry.
   assign seen_out    = seen_in | match_ff;
   assign slot_or_out = slot_or_in | (match_ff ? slot_ff : '0);

   // Decide whether this position shifts down, loads the new entry or holds.
   always_comb begin
      shift_en = 1'b0;
      load_en  = 1'b0;
      case (ctl.op)
         OP_HIT: begin
            shift_en = seen_out && (NEXT_POS < count);
            load_en  = (NEXT_POS == count);
         end
         OP_EVICT: begin
            shift_en = (NEXT_POS < count);
         end
         OP_EVICT_INSERT: begin
            shift_en = (NEXT_POS < count);
            load_en  = (NEXT_POS == count);
         end
         OP_INSERT: begin
            load_en  = (MY_POS == count);
         end
         default: begin
         end
      endcase
      tag_in  = tag_ff;
      slot_in = slot_ff;
      if (shift_en) begin
         tag_in  = up_tag;
         slot_in = up_slot;
      end else if (load_en) begin
         tag_in  = ctl.new_tag;
         slot_in = new_slot;
      end
      match_in = ctl.cmp_en ? (occupied && (tag_ff == ctl.cmp_tag)) : match_ff;
   end

   // Entry and match registers.
   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      slot_ff  <= slot_in;
      match_ff <= match_in;
   end

   assign tag  = tag_ff;
   assign slot = slot_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ltcp_checker.sv =====
// Port-level checks for the LRU tag cache policy block.
// Bound to lru_tag_cache_policy; depends on ltcp_pkg for field widths.
`default_nettype none

module ltcp_checker
   import ltcp_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire logic              rsp_hit,
   input wire logic              rsp_inserted,
   input wire logic              rsp_evicted_valid,
   input wire logic [TAG_W-1:0]  rsp_evicted_index,
   input wire logic              rsp_last
);

   // An accepted item keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not make the block busy");

   // Once the final result of an item is shown, the block is free again.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("block still busy at the final result");

   // A hit is a single result that neither inserts nor evicts.
   a_hit_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (!rsp_inserted && !rsp_evicted_valid && rsp_last))
      else $error("hit result carries insert or eviction");

   // Only trim evictions produce more than one result per item.
   a_multi_is_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_evicted_valid && !rsp_inserted))
      else $error("non-final result without an eviction");

   // With no eviction the evicted index reads zero.
   a_evidx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted_valid) |-> (rsp_evicted_index == '0))
      else $error("evicted index set without an eviction");

endmodule

bind lru_tag_cache_policy ltcp_checker u_ltcp_checker (.*);

`default_nettype wire

// ===== test/tb_lru_tag_cache_policy.sv =====
// Self-checking testbench for the LRU tag cache policy block (lru_tag_cache_policy).
// Depends on ltcp_pkg for the field widths and request codes, and on the block's RTL.
// A built-in LRU predictor computes the expected result items, which are checked in order.
`default_nettype none

module tb_lru_tag_cache_policy;
   import ltcp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 16;
   localparam int CYCLE_LIMIT = 100000;
   localparam int POOL_MAX    = 20;

   // One request as queued for the driver.
   typedef struct {
      ltcp_req_type     kind;
      logic [TAG_W-1:0] tag;
      logic             fill;
   } lru_request_type;

   // One result item as the block should present it.
   typedef struct packed {
      logic                  hit;
      logic                  inserted;
      logic                  ev_valid;
      logic [TAG_W-1:0]      ev_index;
      logic [RSP_SLOT_W-1:0] slot;
      logic [OCC_W-1:0]      occupancy;
      logic                  last;
   } lru_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_type = REQ_NOP;
   logic [TAG_W-1:0]      req_item_index = '0;
   logic                  req_fill_ok = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_hit;
   logic                  rsp_inserted;
   logic                  rsp_evicted_valid;
   logic [TAG_W-1:0]      rsp_evicted_index;
   logic [RSP_SLOT_W-1:0] rsp_slot;
   logic [OCC_W-1:0]      rsp_occupancy;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CAP_W-1:0]      csr_wdata = '0;

   // Predictor state: entries ordered from least recent (0) to most recent.
   logic [TAG_W-1:0]      lru_tag[SLOTS];
   logic [RSP_SLOT_W-1:0] lru_slot[SLOTS];
   logic [SLOTS-1:0]      slot_busy = '0;
   int                    occ = 0;
   logic [CAP_W-1:0]      capacity_reg = CAP_RESET;

   lru_request_type       pending_requests[$];
   lru_result_type        expected_results[$];
   lru_request_type       next_req;
   logic [TAG_W-1:0]      tag_pool[POOL_MAX];
   int                    idle_left = 0;
   bit                    idling_on = 1'b1;
   int                    error_count = 0;
   int                    cycle_count = 0;

   lru_tag_cache_policy u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_item_index    (req_item_index),
      .req_fill_ok       (req_fill_ok),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_inserted      (rsp_inserted),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_index (rsp_evicted_index),
      .rsp_slot          (rsp_slot),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   // Clock with an 8 ns period.
   always #4 clock = ~clock;

   // Capacity as used: at least one entry, at most the store size.
   function automatic int clamp_capacity(input logic [CAP_W-1:0] value);
      int c;
      c = value;
      if (c < 1) c = 1;
      if (c > SLOTS) c = SLOTS;
      return c;
   endfunction

   task automatic record_result(input logic hit, input logic inserted, input logic ev_valid,
                                input logic [TAG_W-1:0] ev_index,
                                input logic [RSP_SLOT_W-1:0] slot, input logic last);
      lru_result_type r;
      r.hit       = hit;
      r.inserted  = inserted;
      r.ev_valid  = ev_valid;
      r.ev_index  = ev_index;
      r.slot      = slot;
      r.occupancy = OCC_W'(occ);
      r.last      = last;
      expected_results = {expected_results, r};
   endtask

   // Drop the entry at one position; newer entries move down by one.
   task automatic remove_entry(input int pos);
      for (int i = pos; i + 1 < occ; i++) begin
         lru_tag[i]  = lru_tag[i + 1];
         lru_slot[i] = lru_slot[i + 1];
      end
      occ--;
   endtask

   task automatic evict_lru_entry(output logic [TAG_W-1:0] tag,
                                  output logic [RSP_SLOT_W-1:0] slot);
      tag  = lru_tag[0];
      slot = lru_slot[0];
      slot_busy[slot] = 1'b0;
      remove_entry(0);
   endtask

   // Work out the result items of one accepted request and update the predicted store.
   task automatic predict_request(input ltcp_req_type kind, input logic [TAG_W-1:0] tag,
                                  input logic fill);
      int                    cap;
      int                    pos;
      int                    evictions;
      logic                  ev;
      logic [TAG_W-1:0]      ev_tag;
      logic [RSP_SLOT_W-1:0] slot;
      cap    = clamp_capacity(capacity_reg);
      ev     = 1'b0;
      ev_tag = '0;
      slot   = '0;
      case (kind)
         REQ_CLEAR: begin
            slot_busy = '0;
            occ       = 0;
            record_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
         end
         REQ_TRIM: begin
            evictions = 0;
            while (occ > cap && evictions < MAX_TRIM) begin
               evict_lru_entry(ev_tag, slot);
               record_result(1'b0, 1'b0, 1'b1, ev_tag, slot, 1'b0);
               evictions++;
            end
            // A trim with nothing to evict still answers once.
            if (evictions == 0)
               record_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
            else
               expected_results[expected_results.size() - 1].last = 1'b1;
         end
         REQ_ACCESS: begin
            pos = -1;
            for (int i = 0; i < occ; i++)
               if (pos < 0 && lru_tag[i] == tag) pos = i;
            if (pos >= 0) begin
               // Hit: the entry becomes the most recent one.
               slot = lru_slot[pos];
               remove_entry(pos);
               lru_tag[occ]  = tag;
               lru_slot[occ] = slot;
               occ++;
               record_result(1'b1, 1'b0, 1'b0, '0, slot, 1'b1);
            end else if (!fill) begin
               record_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
            end else begin
               // Miss with data: reuse the oldest slot when full, else the lowest free one.
               if (occ >= cap && occ > 0) begin
                  evict_lru_entry(ev_tag, slot);
                  ev = 1'b1;
               end else begin
                  pos = 0;
                  while (pos < SLOTS && slot_busy[pos]) pos++;
                  slot = (pos >= SLOTS) ? '0 : RSP_SLOT_W'(pos);
               end
               slot_busy[slot] = 1'b1;
               if (occ < SLOTS) begin
                  lru_tag[occ]  = tag;
                  lru_slot[occ] = slot;
                  occ++;
               end
               record_result(1'b0, 1'b1, ev, ev_tag, slot, 1'b1);
            end
         end
         default: begin
            record_result(1'b0, 1'b0, 1'b0, '0, '0, 1'b1);
         end
      endcase
   endtask

   // Driver: takes items from the pending queue and presents them, with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy)
            predict_request(ltcp_req_type'(req_type), req_item_index, req_fill_ok);
         // An item not yet taken is held unchanged.
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               start     <= 1'b0;
               idle_left <= idle_left - 1;
            end else if (pending_requests.size() > 0 && idling_on &&
                         $urandom_range(0, 3) == 0) begin
               start     <= 1'b0;
               idle_left <= $urandom_range(0, 13);
            end else if (pending_requests.size() > 0) begin
               next_req = pending_requests[0];
               pending_requests.delete(0);
               start          <= 1'b1;
               req_type       <= next_req.kind;
               req_item_index <= next_req.tag;
               req_fill_ok    <= next_req.fill;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Monitor: every strobed result item is compared with the oldest expectation.
   always @(posedge clock) begin
      lru_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual slot 0x%0h occ %0d",
                     $time, rsp_slot, rsp_occupancy);
            error_count++;
         end else begin
            want = expected_results[0];
            expected_results.delete(0);
            check_field("hit", want.hit, rsp_hit);
            check_field("inserted", want.inserted, rsp_inserted);
            check_field("evicted_valid", want.ev_valid, rsp_evicted_valid);
            check_field("evicted_index", want.ev_index, rsp_evicted_index);
            check_field("slot", want.slot, rsp_slot);
            check_field("occupancy", want.occupancy, rsp_occupancy);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic queue_request(input ltcp_req_type kind, input logic [TAG_W-1:0] tag,
                                input logic fill);
      lru_request_type r;
      r.kind = kind;
      r.tag  = tag;
      r.fill = fill;
      pending_requests = {pending_requests, r};
   endtask

   // Wait until every queued item is taken and answered, then let the block settle.
   task automatic wait_drained();
      while (pending_requests.size() != 0 || start || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      capacity_reg = value;
      csr_valid <= 1'b0;
   endtask

   // Random phase: mostly accesses drawn from a tag pool up to four tags larger than the capacity,
   // so that hits, misses and evictions all occur, with trims, clears and no-ops mixed in.
   task automatic run_random_phase(input logic [CAP_W-1:0] cap_value, input int n_items,
                                   input bit with_idling);
      int pool_n;
      int pick;
      idling_on = with_idling;
      write_capacity(cap_value);
      pool_n = clamp_capacity(cap_value) + $urandom_range(0, 4);
      for (int i = 0; i < pool_n; i++) tag_pool[i] = TAG_W'($urandom());
      // A trim first, so that lowering the capacity gives long eviction runs.
      queue_request(REQ_TRIM, TAG_W'($urandom()), 1'($urandom_range(0, 1)));
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 78)
            queue_request(REQ_ACCESS, tag_pool[$urandom_range(0, pool_n - 1)],
                          $urandom_range(0, 7) != 0);
         else if (pick < 86)
            queue_request(REQ_ACCESS, TAG_W'($urandom()), 1'($urandom_range(0, 1)));
         else if (pick < 93)
            queue_request(REQ_TRIM, TAG_W'($urandom()), 1'($urandom_range(0, 1)));
         else if (pick < 97)
            queue_request(REQ_NOP, TAG_W'($urandom()), 1'($urandom_range(0, 1)));
         else
            queue_request(REQ_CLEAR, TAG_W'($urandom()), 1'($urandom_range(0, 1)));
      end
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset capacity: no-op, clear and trim on an empty store, extreme tags,
      // a failed fill, and a hit that ignores its fill flag.
      queue_request(REQ_NOP, '1, 1'b1);
      queue_request(REQ_CLEAR, '0, 1'b0);
      queue_request(REQ_TRIM, '0, 1'b0);
      queue_request(REQ_ACCESS, '0, 1'b0);
      queue_request(REQ_ACCESS, '1, 1'b1);
      queue_request(REQ_ACCESS, '0, 1'b1);
      queue_request(REQ_ACCESS, '1, 1'b0);
      queue_request(REQ_ACCESS, 31'h2AAA_AAAA, 1'b1);
      queue_request(REQ_ACCESS, 31'h5555_5555, 1'b1);
      wait_drained();

      // Capacity zero acts as one: an access above capacity evicts only one entry,
      // and the trim item then removes the rest, one result per eviction.
      write_capacity('0);
      queue_request(REQ_ACCESS, 31'h1234_5678, 1'b1);
      queue_request(REQ_TRIM, '0, 1'b0);
      queue_request(REQ_ACCESS, 31'h1234_5678, 1'b1);
      queue_request(REQ_ACCESS, 31'h0F0F_0F0F, 1'b1);
      wait_drained();

      // Small capacity: fill, hit, miss when full, failed fill, trim with nothing to do.
      write_capacity(5'd3);
      queue_request(REQ_CLEAR, '0, 1'b1);
      queue_request(REQ_ACCESS, 31'd1, 1'b1);
      queue_request(REQ_ACCESS, 31'd2, 1'b1);
      queue_request(REQ_ACCESS, 31'd3, 1'b1);
      queue_request(REQ_ACCESS, 31'd1, 1'b1);
      queue_request(REQ_ACCESS, 31'd4, 1'b1);
      queue_request(REQ_ACCESS, 31'd5, 1'b0);
      queue_request(REQ_TRIM, '1, 1'b1);
      wait_drained();

      // Random part; the last phase runs without idle gaps.
      run_random_phase(5'd31, 16, 1'b1);
      run_random_phase(5'd2, 16, 1'b1);
      run_random_phase(5'd16, 16, 1'b1);
      run_random_phase(5'd1, 16, 1'b1);
      run_random_phase(CAP_W'($urandom_range(0, 31)), 16, 1'b1);
      run_random_phase(CAP_W'($urandom_range(3, 12)), 16, 1'b0);

      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
